@@ design/drvk_pkg.sv @@
`timescale 1ns / 1ps

package drvk_pkg;

	localparam logic [1:0] MODE_OMNI3   = 2'd0;
	localparam logic [1:0] MODE_OMNI4   = 2'd1;
	localparam logic [1:0] MODE_MECANUM = 2'd2;
	localparam logic [1:0] MODE_SWERVE  = 2'd3;

	localparam logic [1:0] REG_DRIVE_MODE     = 2'd0;
	localparam logic [1:0] REG_ROBOT_DIAMETER = 2'd1;
	localparam logic [1:0] REG_WHEEL_RADIUS   = 2'd2;

	localparam int ZW           = 34;
	localparam int DEN_W        = 36;
	localparam int QW           = 32;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORNERS      = 4;

	// rad per degree and sqrt(2) rad per degree, Q32
	localparam logic signed [27:0] DEG_RAD_Q32       = 28'sd74961321;
	localparam logic signed [27:0] DEG_RAD_SQRT2_Q32 = 28'sd106011316;
	localparam logic signed [33:0] HALF_SQRT3_Q32    = 34'sd3719550787;
	localparam logic signed [32:0] HALF_SQRT2_Q32    = 33'sd3037000500;
	localparam logic [18:0]        TWO_PI_Q16        = 19'd411775;
	localparam logic [19:0]        TWO_PI_GAIN_Q16   = 20'd678094;
	localparam logic signed [ZW-1:0] HALF_TURN_Q24   = 34'sd3019898880;

	typedef logic signed [63:0]    wide_t;
	typedef logic signed [ZW-1:0]  ang_t;
	typedef logic [DEN_W-1:0]      den_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic fz;
	} div_flags_t;

	// atan(2^-i) in degrees, Q6.24
	function automatic logic [29:0] atan_deg_q24(input int idx);
		logic [29:0] v;
		case (idx)
			0: v = 30'd754974720;
			1: v = 30'd445687602;
			2: v = 30'd235489089;
			3: v = 30'd119537938;
			4: v = 30'd60000934;
			5: v = 30'd30029717;
			6: v = 30'd15018523;
			7: v = 30'd7509719;
			8: v = 30'd3754917;
			9: v = 30'd1877466;
			10: v = 30'd938734;
			11: v = 30'd469367;
			12: v = 30'd234684;
			13: v = 30'd117342;
			14: v = 30'd58671;
			15: v = 30'd29335;
			16: v = 30'd14668;
			17: v = 30'd7334;
			18: v = 30'd3667;
			19: v = 30'd1833;
			20: v = 30'd917;
			21: v = 30'd458;
			22: v = 30'd229;
			23: v = 30'd115;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ design/drive_wheel_kinematics.sv @@
`timescale 1ns / 1ps

// Channel   | Signals                                | Transfer
// ----------+----------------------------------------+-----------------------------
// command   | start, busy, vel_x, vel_y, turn_rate   | edge with start=1, busy=0
// result    | done, target_0..target_7, zero_command | edge ending the done cycle
// config    | cfg_we, cfg_index, cfg_data            | edge with cfg_we=1
//
// Fully pipelined: one command per cycle. Stages: 3 multiply/sum stages, one
// pre-rotation stage, the CORDIC stages, one divider setup stage, 32 restoring
// division stages, one saturation/output stage.
// busy is always low; results cannot be held off, so nothing ever stalls.
// arst_n clears the valid chain and loads the register reset values.
module drive_wheel_kinematics #(
	parameter int CORDIC_STAGES = 16,
	parameter int TARGET_COUNT  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] turn_rate,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] target_0,
	output logic signed [31:0] target_1,
	output logic signed [31:0] target_2,
	output logic signed [31:0] target_3,
	output logic signed [31:0] target_4,
	output logic signed [31:0] target_5,
	output logic signed [31:0] target_6,
	output logic signed [31:0] target_7,
	output logic               zero_command
);

	import drvk_pkg::*;

	localparam int NS        = CORDIC_STAGES;
	localparam int DIV_STEPS = QW;
	localparam int LAT       = NS + DIV_STEPS + 6;

	logic [1:0]  drive_mode_q;
	logic [15:0] robot_diameter_q;
	logic [15:0] wheel_radius_q;
	den_t        den_q;
	den_t        sden_q;
	logic [LAT-1:0] vld_q;
	logic        swerve;

	assign busy   = 1'b0;
	assign done   = vld_q[LAT-1];
	assign swerve = (drive_mode_q == MODE_SWERVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q     <= MODE_OMNI3;
			robot_diameter_q <= 16'd1000;
			wheel_radius_q   <= 16'd50;
			vld_q            <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
			if (cfg_we) begin
				case (cfg_index)
					REG_DRIVE_MODE:     drive_mode_q     <= cfg_data[1:0];
					REG_ROBOT_DIAMETER: robot_diameter_q <= cfg_data;
					REG_WHEEL_RADIUS:   wheel_radius_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// the user must change config only while the pipe is empty (not enforced here), so these settle in time
	always_ff @(posedge clk) begin
		den_q  <= DEN_W'(wheel_radius_q * TWO_PI_Q16);
		sden_q <= DEN_W'(wheel_radius_q * TWO_PI_GAIN_Q16);
	end

	// stage 1: diameter times rate, difference and sum of the axes
	logic signed [32:0] pdr_s1;
	logic signed [16:0] vsub_s1, vadd_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic               zero_s1;

	always_ff @(posedge clk) begin
		pdr_s1  <= $signed({1'b0, robot_diameter_q}) * turn_rate;
		vsub_s1 <= 17'(vel_x) - 17'(vel_y);
		vadd_s1 <= 17'(vel_x) + 17'(vel_y);
		vx_s1   <= vel_x;
		vy_s1   <= vel_y;
		zero_s1 <= (vel_x == 16'sd0) && (vel_y == 16'sd0) && (turn_rate == 16'sd0);
	end

	// stage 2: constant multiplies
	logic signed [60:0] t_s2, c_s2;
	logic signed [49:0] sy_s2, msub_s2, madd_s2;
	logic signed [48:0] hx_s2, hy_s2;
	logic signed [15:0] vx_s2, vy_s2;
	logic               zero_s2;

	always_ff @(posedge clk) begin
		t_s2    <= pdr_s1 * DEG_RAD_Q32;
		c_s2    <= pdr_s1 * DEG_RAD_SQRT2_Q32;
		sy_s2   <= vy_s1 * HALF_SQRT3_Q32;
		hx_s2   <= vx_s1 * HALF_SQRT2_Q32;
		hy_s2   <= vy_s1 * HALF_SQRT2_Q32;
		msub_s2 <= vsub_s1 * HALF_SQRT2_Q32;
		madd_s2 <= vadd_s1 * HALF_SQRT2_Q32;
		vx_s2   <= vx_s1;
		vy_s2   <= vy_s1;
		zero_s2 <= zero_s1;
	end

	// stage 3: wheel numerators or swerve corner vectors
	wide_t x_n3 [CORNERS];
	wide_t y_n3 [CORNERS];
	wide_t e_n3 [CORNERS];
	wide_t x_s3 [CORNERS];
	wide_t y_s3 [CORNERS];
	wide_t e_s3 [CORNERS];
	logic  zero_s3;

	always_comb begin
		wide_t t, c, lx, ly, hx0, sy, hx, hy, ms, ma;
		t   = 64'(t_s2);
		c   = 64'(c_s2);
		lx  = {{16{vx_s2[15]}}, vx_s2, 32'd0};
		ly  = {{16{vy_s2[15]}}, vy_s2, 32'd0};
		hx0 = {{17{vx_s2[15]}}, vx_s2, 31'd0};
		sy  = 64'(sy_s2);
		hx  = 64'(hx_s2);
		hy  = 64'(hy_s2);
		ms  = 64'(msub_s2);
		ma  = 64'(madd_s2);
		for (int k = 0; k < CORNERS; k++) begin
			x_n3[k] = '0;
			y_n3[k] = '0;
			e_n3[k] = '0;
		end
		case (drive_mode_q)
			MODE_OMNI3: begin
				x_n3[0] = t - lx;
				x_n3[1] = hx0 - sy + t;
				x_n3[2] = hx0 + sy + t;
			end
			MODE_OMNI4: begin
				x_n3[0] = hy - hx - t;
				x_n3[1] = hx + hy + t;
				x_n3[2] = t - hx - hy;
				x_n3[3] = hy - hx + t;
				e_n3[0] = lx - t;
				e_n3[1] = t - ly;
				e_n3[2] = lx + t;
				e_n3[3] = ly + t;
			end
			MODE_MECANUM: begin
				x_n3[0] = ms + t;
				x_n3[1] = t - ma;
				x_n3[2] = t - ms;
				x_n3[3] = ma + t;
			end
			default: begin
				x_n3[0] = lx - c;  y_n3[0] = ly + c;
				x_n3[1] = lx - c;  y_n3[1] = ly - c;
				x_n3[2] = lx + c;  y_n3[2] = ly - c;
				x_n3[3] = lx + c;  y_n3[3] = ly + c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		x_s3    <= x_n3;
		y_s3    <= y_n3;
		e_s3    <= e_n3;
		zero_s3 <= zero_s2;
	end

	// CORDIC chain: index 0 is the pre-rotation stage
	wide_t      cx_c  [NS+1][CORNERS];
	wide_t      cy_c  [NS+1][CORNERS];
	ang_t       cz_c  [NS+1][CORNERS];
	wide_t      ce_c  [NS+1][CORNERS];
	logic [3:0] czr_c [NS+1];
	logic       czc_c [NS+1];
	wide_t      cx_n  [NS+1][CORNERS];
	wide_t      cy_n  [NS+1][CORNERS];
	ang_t       cz_n  [NS+1][CORNERS];

	always_comb begin
		ang_t a;
		for (int k = 0; k < CORNERS; k++) begin
			cx_n[0][k] = x_s3[k];
			cy_n[0][k] = y_s3[k];
			cz_n[0][k] = '0;
			if (swerve && x_s3[k] < 0) begin
				cx_n[0][k] = -x_s3[k];
				cy_n[0][k] = -y_s3[k];
				cz_n[0][k] = (y_s3[k] >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
			end
		end
		for (int j = 1; j <= NS; j++) begin
			a = $signed({4'd0, atan_deg_q24(j - 1)});
			for (int k = 0; k < CORNERS; k++) begin
				cx_n[j][k] = cx_c[j-1][k];
				cy_n[j][k] = cy_c[j-1][k];
				cz_n[j][k] = cz_c[j-1][k];
				if (swerve) begin
					if (cy_c[j-1][k] > 0) begin
						cx_n[j][k] = cx_c[j-1][k] + (cy_c[j-1][k] >>> (j - 1));
						cy_n[j][k] = cy_c[j-1][k] - (cx_c[j-1][k] >>> (j - 1));
						cz_n[j][k] = cz_c[j-1][k] + a;
					end else begin
						cx_n[j][k] = cx_c[j-1][k] - (cy_c[j-1][k] >>> (j - 1));
						cy_n[j][k] = cy_c[j-1][k] + (cx_c[j-1][k] >>> (j - 1));
						cz_n[j][k] = cz_c[j-1][k] - a;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cx_c <= cx_n;
		cy_c <= cy_n;
		cz_c <= cz_n;
		ce_c[0] <= e_s3;
		czc_c[0] <= zero_s3;
		for (int k = 0; k < CORNERS; k++)
			czr_c[0][k] <= (x_s3[k] == 0) && (y_s3[k] == 0);
		for (int j = 1; j <= NS; j++) begin
			ce_c[j]  <= ce_c[j-1];
			czr_c[j] <= czr_c[j-1];
			czc_c[j] <= czc_c[j-1];
		end
	end

	// restoring division, one quotient bit per stage
	den_t        lden [TARGET_COUNT];
	den_t        rem_d [DIV_STEPS+1][TARGET_COUNT];
	logic [QW-1:0] low_d [DIV_STEPS+1][TARGET_COUNT];
	logic [QW-1:0] q_d   [DIV_STEPS+1][TARGET_COUNT];
	div_flags_t  fl_d  [DIV_STEPS+1][TARGET_COUNT];
	logic [31:0] ang_d [DIV_STEPS+1][CORNERS];
	logic        zc_d  [DIV_STEPS+1];
	den_t        rem_n [DIV_STEPS+1][TARGET_COUNT];
	logic [QW-1:0] low_n [DIV_STEPS+1][TARGET_COUNT];
	logic [QW-1:0] q_n   [DIV_STEPS+1][TARGET_COUNT];
	div_flags_t  fl_n  [TARGET_COUNT];
	logic [31:0] ang_n [CORNERS];

	always_comb begin
		wide_t       num;
		logic [63:0] mag;
		logic [64:0] dvd;
		logic [DEN_W:0] r2;
		ang_t        zr;
		for (int k = 0; k < TARGET_COUNT; k++)
			lden[k] = (k < CORNERS && swerve) ? sden_q : den_q;
		for (int k = 0; k < TARGET_COUNT; k++) begin
			if (k < CORNERS)
				num = cx_c[NS][k % CORNERS];
			else
				num = swerve ? 64'sd0 : ce_c[NS][k % CORNERS];
			mag = (num < 0) ? 64'(-num) : 64'(num);
			dvd = {1'b0, mag} + 65'(lden[k] >> 1);
			fl_n[k].neg = (num < 0);
			fl_n[k].ovf = ({3'd0, dvd[64:32]} >= lden[k]);
			fl_n[k].fz  = (lden[k] == '0) && (mag == 64'd0);
			rem_n[0][k] = fl_n[k].ovf ? '0 : DEN_W'(dvd[64:32]);
			low_n[0][k] = dvd[31:0];
			q_n[0][k]   = '0;
		end
		for (int k = 0; k < CORNERS; k++) begin
			zr = (cz_c[NS][k] + ang_t'(128)) >>> 8;
			ang_n[k] = czr_c[NS][k] ? 32'd0 : 32'(zr);
		end
		for (int i = 1; i <= DIV_STEPS; i++) begin
			for (int k = 0; k < TARGET_COUNT; k++) begin
				r2 = {rem_d[i-1][k], low_d[i-1][k][QW-1]};
				low_n[i][k] = {low_d[i-1][k][QW-2:0], 1'b0};
				if (r2 >= {1'b0, lden[k]}) begin
					rem_n[i][k] = DEN_W'(r2 - {1'b0, lden[k]});
					q_n[i][k]   = {q_d[i-1][k][QW-2:0], 1'b1};
				end else begin
					rem_n[i][k] = DEN_W'(r2);
					q_n[i][k]   = {q_d[i-1][k][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_d <= rem_n;
		low_d <= low_n;
		q_d   <= q_n;
		fl_d[0]  <= fl_n;
		ang_d[0] <= ang_n;
		zc_d[0]  <= czc_c[NS];
		for (int i = 1; i <= DIV_STEPS; i++) begin
			fl_d[i]  <= fl_d[i-1];
			ang_d[i] <= ang_d[i-1];
			zc_d[i]  <= zc_d[i-1];
		end
	end

	// saturate the quotients (swerve angles on targets 4..7) and drive the result ports
	logic signed [31:0] res [TARGET_COUNT];

	always_comb begin
		logic [QW-1:0] q;
		div_flags_t    f;
		for (int k = 0; k < TARGET_COUNT; k++) begin
			q = q_d[DIV_STEPS][k];
			f = fl_d[DIV_STEPS][k];
			if (f.fz)
				res[k] = 32'sd0;
			else if (f.ovf || q[QW-1])
				res[k] = f.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			else
				res[k] = f.neg ? -$signed(q) : $signed(q);
			if (k >= CORNERS && swerve)
				res[k] = $signed(ang_d[DIV_STEPS][k % CORNERS]);
		end
	end

	always_ff @(posedge clk) begin
		target_0     <= res[0];
		target_1     <= res[1];
		target_2     <= res[2];
		target_3     <= res[3];
		target_4     <= res[4];
		target_5     <= res[5];
		target_6     <= res[6];
		target_7     <= res[7];
		zero_command <= zc_d[DIV_STEPS];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted command did not produce a result on time");

	a_zero_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_command |-> target_0 == 0 && target_1 == 0 && target_2 == 0
			&& target_3 == 0 && target_4 == 0 && target_5 == 0 && target_6 == 0
			&& target_7 == 0)
		else $error("zero command gave a nonzero target");

	a_omni3_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && drive_mode_q == MODE_OMNI3 |-> target_3 == 0 && target_4 == 0
			&& target_5 == 0 && target_6 == 0 && target_7 == 0)
		else $error("three-wheel mode drove an unused target");

	a_mecanum_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && drive_mode_q == MODE_MECANUM |-> target_4 == 0 && target_5 == 0
			&& target_6 == 0 && target_7 == 0)
		else $error("mecanum mode drove an unused target");

endmodule
